[src/v2p_pkg.sv]
// ============================================================================
// v2p_pkg
// shared types, constants and constant functions of the vector unit
// ============================================================================
package v2p_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRAC_BITS     = 16;
    localparam int GUARD_BITS    = 8;

    localparam int XW         = 32;  // vector component width
    localparam int CW         = 44;  // cordic x/y width, signed
    localparam int ZW         = 34;  // cordic angle width, signed, radians q30
    localparam int RW         = 34;  // full-circle angle width, unsigned q30
    localparam int DW         = 64;  // divider numerator width
    localparam int DIV_STAGES = 4;   // register stages of one constant divider
    localparam int QW         = 34;  // divider quotient width
    localparam int MW         = 34;  // reciprocal width

    // sideband shift line: cordic entry, cordic cells, two prep stages, divider stages
    localparam int SB_LEN  = CORDIC_STAGES + 3 + DIV_STAGES;
    localparam int LATENCY = SB_LEN + 2;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] DEG90_Q16   = 64'd5898240;
    localparam logic [63:0] DEG180_Q16  = 64'd11796480;
    localparam logic [63:0] DEG270_Q16  = 64'd17694720;
    localparam logic [63:0] DEG360_Q16  = 64'd23592960;

    typedef enum logic [2:0] {
        FN_LOAD   = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_NEG    = 3'd3,
        FN_SCALE  = 3'd4,
        FN_LONGER = 3'd5
    } t_func;

    typedef struct packed {
        logic                 vld;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 sat;
    } t_vec;

    // atan(2^-i) in radians q30
    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic [ZW-1:0] v;
        v = '0;
        unique case (idx)
            5'd0:    v = ZW'(64'd843314857);
            5'd1:    v = ZW'(64'd497837829);
            5'd2:    v = ZW'(64'd263043836);
            5'd3:    v = ZW'(64'd133525158);
            5'd4:    v = ZW'(64'd67021686);
            5'd5:    v = ZW'(64'd33543515);
            5'd6:    v = ZW'(64'd16775850);
            5'd7:    v = ZW'(64'd8388437);
            5'd8:    v = ZW'(64'd4194282);
            5'd9:    v = ZW'(64'd2097149);
            5'd31:   v = '0;
            default: v = ZW'(64'd1) << (5'd30 - idx);
        endcase
        return v;
    endfunction

    // cordic gain in q30, floor of the square root of the stage product
    function automatic logic [63:0] calc_kq();
        logic [63:0] k2;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        k2 = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            k2 = k2 + (k2 >> (2 * i));
        end
        n = k2;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r == 64'd0) begin
            r = 64'd1;
        end
        return r;
    endfunction

    localparam logic [63:0] KQ = calc_kq();

    // floor(2^64 / divisor), the estimate is then at most one below the quotient
    localparam logic [MW-1:0] RECIP_MAG = MW'((128'd1 << 64) / 128'(KQ));
    localparam logic [MW-1:0] RECIP_PI  = MW'((128'd1 << 64) / 128'(PI_Q30));

endpackage

[src/v2p_alu.sv]
// ============================================================================
// v2p_alu
// vector operation front end: products, operation select and saturation
// ============================================================================
module v2p_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [2:0]                    i_func,
    input  logic signed [v2p_pkg::XW-1:0] i_a_x,
    input  logic signed [v2p_pkg::XW-1:0] i_a_y,
    input  logic signed [v2p_pkg::XW-1:0] i_b_x,
    input  logic signed [v2p_pkg::XW-1:0] i_b_y,
    input  logic signed [v2p_pkg::XW-1:0] i_scale,
    output v2p_pkg::t_vec                 o_vec
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (v2p_pkg::FRAC_BITS - 1);
    localparam logic signed [64:0] SMAX = 65'sd2147483647;
    localparam logic signed [64:0] SMIN = -65'sd2147483648;

    // stage a: operands and products
    logic                 r_a_vld;
    logic [2:0]           r_func;
    logic signed [31:0]   r_ax, r_ay, r_bx, r_by;
    logic signed [63:0]   r_pa_x, r_pa_y, r_pb_x, r_pb_y;
    logic signed [31:0]   n_mx, n_my;

    // stage b
    v2p_pkg::t_vec        r_out;
    logic signed [64:0]   n_wx, n_wy;
    logic signed [63:0]   n_sx, n_sy;
    logic [63:0]          n_ua, n_ub;
    logic                 n_sat;

    always_comb begin
        n_mx = (v2p_pkg::t_func'(i_func) == v2p_pkg::FN_SCALE) ? i_scale : i_a_x;
        n_my = (v2p_pkg::t_func'(i_func) == v2p_pkg::FN_SCALE) ? i_scale : i_a_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start && !i_busy;
        end
        r_func <= i_func;
        r_ax   <= i_a_x;
        r_ay   <= i_a_y;
        r_bx   <= i_b_x;
        r_by   <= i_b_y;
        r_pa_x <= 64'(i_a_x) * 64'(n_mx);
        r_pa_y <= 64'(i_a_y) * 64'(n_my);
        r_pb_x <= 64'(i_b_x) * 64'(i_b_x);
        r_pb_y <= 64'(i_b_y) * 64'(i_b_y);
    end

    always_comb begin
        n_sx = (r_pa_x + HALF) >>> v2p_pkg::FRAC_BITS;
        n_sy = (r_pa_y + HALF) >>> v2p_pkg::FRAC_BITS;
        n_ua = $unsigned(r_pa_x) + $unsigned(r_pa_y);
        n_ub = $unsigned(r_pb_x) + $unsigned(r_pb_y);
        n_wx = {{33{r_ax[31]}}, r_ax};
        n_wy = {{33{r_ay[31]}}, r_ay};
        unique case (v2p_pkg::t_func'(r_func))
            v2p_pkg::FN_ADD: begin
                n_wx = {{33{r_ax[31]}}, r_ax} + {{33{r_bx[31]}}, r_bx};
                n_wy = {{33{r_ay[31]}}, r_ay} + {{33{r_by[31]}}, r_by};
            end
            v2p_pkg::FN_SUB: begin
                n_wx = {{33{r_ax[31]}}, r_ax} - {{33{r_bx[31]}}, r_bx};
                n_wy = {{33{r_ay[31]}}, r_ay} - {{33{r_by[31]}}, r_by};
            end
            v2p_pkg::FN_NEG: begin
                n_wx = -{{33{r_ax[31]}}, r_ax};
                n_wy = -{{33{r_ay[31]}}, r_ay};
            end
            v2p_pkg::FN_SCALE: begin
                n_wx = {n_sx[63], n_sx};
                n_wy = {n_sy[63], n_sy};
            end
            v2p_pkg::FN_LONGER: begin
                if (n_ub > n_ua) begin
                    n_wx = {{33{r_bx[31]}}, r_bx};
                    n_wy = {{33{r_by[31]}}, r_by};
                end
            end
            default: begin
            end
        endcase
        n_sat = 1'b0;
        if (n_wx > SMAX) begin
            n_wx  = SMAX;
            n_sat = 1'b1;
        end else if (n_wx < SMIN) begin
            n_wx  = SMIN;
            n_sat = 1'b1;
        end
        if (n_wy > SMAX) begin
            n_wy  = SMAX;
            n_sat = 1'b1;
        end else if (n_wy < SMIN) begin
            n_wy  = SMIN;
            n_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= r_a_vld;
        end
        r_out.x   <= n_wx[31:0];
        r_out.y   <= n_wy[31:0];
        r_out.sat <= n_sat;
    end

    assign o_vec = r_out;

endmodule

[src/v2p_cordic_cell.sv]
// ============================================================================
// v2p_cordic_cell
// one vectoring micro-rotation with its output registered
// ============================================================================
module v2p_cordic_cell (
    input  logic                          i_clk,
    input  logic [4:0]                    i_idx,
    input  logic signed [v2p_pkg::CW-1:0] i_x,
    input  logic signed [v2p_pkg::CW-1:0] i_y,
    input  logic signed [v2p_pkg::ZW-1:0] i_z,
    output logic signed [v2p_pkg::CW-1:0] o_x,
    output logic signed [v2p_pkg::CW-1:0] o_y,
    output logic signed [v2p_pkg::ZW-1:0] o_z
);

    logic signed [v2p_pkg::CW-1:0] r_x, r_y;
    logic signed [v2p_pkg::ZW-1:0] r_z;
    logic signed [v2p_pkg::CW-1:0] n_dx, n_dy;
    logic signed [v2p_pkg::ZW-1:0] n_at;

    always_comb begin
        n_dx = i_y >>> i_idx;
        n_dy = i_x >>> i_idx;
        n_at = $signed(v2p_pkg::atan_entry(i_idx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_y[v2p_pkg::CW-1]) begin
            r_x <= i_x + n_dx;
            r_y <= i_y - n_dy;
            r_z <= i_z + n_at;
        end else begin
            r_x <= i_x - n_dx;
            r_y <= i_y + n_dy;
            r_z <= i_z - n_at;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

[src/v2p_div_cell.sv]
// ============================================================================
// v2p_div_cell
// division by a fixed divisor through its reciprocal, four registered stages
// ============================================================================
module v2p_div_cell (
    input  logic                   i_clk,
    input  logic [v2p_pkg::DW-1:0] i_num,
    input  logic [31:0]            i_div,
    input  logic [v2p_pkg::MW-1:0] i_recip,
    output logic [v2p_pkg::QW-1:0] o_q
);

    localparam int DW = v2p_pkg::DW;
    localparam int QW = v2p_pkg::QW;
    localparam int MW = v2p_pkg::MW;
    localparam int PW = DW + MW;

    // stage 1: numerator split in three slices, one partial product each
    logic [DW-1:0]    r_n1, r_n2, r_n3;
    logic [22+MW-1:0] r_p0, r_p1;
    logic [20+MW-1:0] r_p2;
    // stage 2 and 3: estimate, then its product with the divisor
    logic [PW-1:0]    n_sum;
    logic [QW-1:0]    r_qe2, r_qe3;
    logic [DW+1:0]    r_pd;
    logic [DW+1:0]    n_rem;
    logic [QW-1:0]    r_q;

    always_comb begin
        n_sum = PW'(r_p0) + (PW'(r_p1) << 22) + (PW'(r_p2) << 44);
        n_rem = (DW+2)'(r_n3) - r_pd;
    end

    always_ff @(posedge i_clk) begin
        r_n1  <= i_num;
        r_p0  <= (22+MW)'(i_num[21:0]) * (22+MW)'(i_recip);
        r_p1  <= (22+MW)'(i_num[43:22]) * (22+MW)'(i_recip);
        r_p2  <= (20+MW)'(i_num[63:44]) * (20+MW)'(i_recip);
        r_n2  <= r_n1;
        r_qe2 <= n_sum[PW-1:64];
        r_n3  <= r_n2;
        r_qe3 <= r_qe2;
        r_pd  <= (DW+2)'(r_qe2) * (DW+2)'(i_div);
        // estimate is low by at most one
        r_q   <= (n_rem >= (DW+2)'(i_div)) ? (r_qe3 + QW'(1)) : r_qe3;
    end

    assign o_q = r_q;

endmodule

[src/vector2d_alu_with_polar_top.sv]
// ============================================================================
// vector2d_alu_with_polar_top
// 2-d vector unit with saturation and a pipelined cartesian-to-polar stage
// ============================================================================
// path: the strobe o_done is registered behind the alu stages, the sideband line and the output register
// throughput: one word per clock, every stage moves on each cycle, o_busy only in reset
// the depth is set by the 24 cordic cells and the four-stage reciprocal dividers
// reset: synchronous, active low; clears all valid flags, payload is left as is
// results cannot be held off, each is shown for exactly one cycle
module vector2d_alu_with_polar_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_func,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_scale,
    output logic        o_done,
    output logic signed [31:0] o_res_x,
    output logic signed [31:0] o_res_y,
    output logic [31:0] o_magnitude,
    output logic [24:0] o_angle_deg,
    output logic        o_saturated
);

    localparam int N  = v2p_pkg::CORDIC_STAGES;
    localparam int CW = v2p_pkg::CW;
    localparam int ZW = v2p_pkg::ZW;
    localparam int RW = v2p_pkg::RW;
    localparam int DW = v2p_pkg::DW;
    localparam int QW = v2p_pkg::QW;
    localparam int SB = v2p_pkg::SB_LEN;

    localparam logic [RW-1:0] PI_R    = RW'(v2p_pkg::PI_Q30);
    localparam logic [RW-1:0] TWOPI_R = RW'(v2p_pkg::PI_Q30 << 1);
    localparam logic signed [ZW-1:0] HPI_Z = ZW'(v2p_pkg::HALF_PI_Q30);

    // busy only while reset holds the pipe
    assign o_busy = !i_rst_n;

    // front end: operation and saturation
    v2p_pkg::t_vec w_vec;

    v2p_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_busy  (o_busy),
        .i_func  (i_func),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_scale (i_scale),
        .o_vec   (w_vec)
    );

    // sideband line: the saturated vector travels alongside the polar pipe
    v2p_pkg::t_vec r_sb [SB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SB; k++) begin
                r_sb[k].vld <= 1'b0;
            end
        end else begin
            r_sb[0].vld <= w_vec.vld;
            for (int k = 1; k < SB; k++) begin
                r_sb[k].vld <= r_sb[k-1].vld;
            end
        end
        r_sb[0].x   <= w_vec.x;
        r_sb[0].y   <= w_vec.y;
        r_sb[0].sat <= w_vec.sat;
        for (int k = 1; k < SB; k++) begin
            r_sb[k].x   <= r_sb[k-1].x;
            r_sb[k].y   <= r_sb[k-1].y;
            r_sb[k].sat <= r_sb[k-1].sat;
        end
    end

    // cordic entry: absolute values with guard bits, first quadrant
    logic [31:0] n_abs_x, n_abs_y;
    logic signed [CW-1:0] r_c_x, r_c_y;

    assign n_abs_x = w_vec.x[31] ? (~w_vec.x + 32'd1) : w_vec.x;
    assign n_abs_y = w_vec.y[31] ? (~w_vec.y + 32'd1) : w_vec.y;

    always_ff @(posedge i_clk) begin
        r_c_x <= $signed(CW'({n_abs_x, {v2p_pkg::GUARD_BITS{1'b0}}}));
        r_c_y <= $signed(CW'({n_abs_y, {v2p_pkg::GUARD_BITS{1'b0}}}));
    end

    // row of cordic cells, one micro-rotation each
    logic signed [CW-1:0] w_cx [N+1];
    logic signed [CW-1:0] w_cy [N+1];
    logic signed [ZW-1:0] w_cz [N+1];

    assign w_cx[0] = r_c_x;
    assign w_cy[0] = r_c_y;
    assign w_cz[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cordic
        v2p_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_idx (5'(k)),
            .i_x   (w_cx[k]),
            .i_y   (w_cy[k]),
            .i_z   (w_cz[k]),
            .o_x   (w_cx[k+1]),
            .o_y   (w_cy[k+1]),
            .o_z   (w_cz[k+1])
        );
    end

    // clamp angle, unfold quadrant, scale length for the gain division
    logic signed [ZW-1:0] n_zc;
    logic [RW-1:0]        n_zr, n_rad;
    logic                 n_xneg, n_yneg, n_xpos, n_ypos;
    logic [RW-1:0]        r_d_rad;
    logic [DW-1:0]        r_d_num;

    always_comb begin
        n_zc = w_cz[N];
        if (n_zc < 0) begin
            n_zc = '0;
        end else if (n_zc > HPI_Z) begin
            n_zc = HPI_Z;
        end
        n_zr   = $unsigned(n_zc);
        n_xneg = r_sb[N].x[31];
        n_yneg = r_sb[N].y[31];
        n_xpos = !n_xneg && (r_sb[N].x != '0);
        n_ypos = !n_yneg && (r_sb[N].y != '0);
        priority if (n_xpos && n_ypos) begin
            n_rad = n_zr;
        end else if (n_xneg && n_ypos) begin
            n_rad = PI_R - n_zr;
        end else if (n_xneg) begin
            n_rad = PI_R + n_zr;
        end else begin
            n_rad = TWOPI_R - n_zr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rad <= n_rad;
        r_d_num <= (DW'($unsigned(w_cx[N])) << (30 - v2p_pkg::GUARD_BITS))
                 + DW'(v2p_pkg::KQ >> 1);
    end

    // radians to degrees numerator, one multiply by the 180 degree constant
    logic [RW+23:0] n_dprod;
    logic [DW-1:0]  r_e_ang;
    logic [DW-1:0]  r_e_num;

    assign n_dprod = (RW+24)'(r_d_rad) * (RW+24)'(v2p_pkg::DEG180_Q16[23:0]);

    always_ff @(posedge i_clk) begin
        r_e_ang <= DW'(n_dprod) + DW'(v2p_pkg::HALF_PI_Q30);
        r_e_num <= r_d_num;
    end

    // two constant dividers side by side: length by gain, angle by pi
    logic [QW-1:0] w_mq;
    logic [QW-1:0] w_aq;

    v2p_div_cell u_mag (
        .i_clk   (i_clk),
        .i_num   (r_e_num),
        .i_div   (32'(v2p_pkg::KQ)),
        .i_recip (v2p_pkg::RECIP_MAG),
        .o_q     (w_mq)
    );

    v2p_div_cell u_ang (
        .i_clk   (i_clk),
        .i_num   (r_e_ang),
        .i_div   (32'(v2p_pkg::PI_Q30)),
        .i_recip (v2p_pkg::RECIP_PI),
        .o_q     (w_aq)
    );

    // output stage: axis and zero cases bypass the cordic result
    v2p_pkg::t_vec w_last;
    logic [31:0]   n_mag, n_ax, n_ay;
    logic [24:0]   n_deg;
    logic          r_done;
    logic signed [31:0] r_res_x, r_res_y;
    logic [31:0]   r_mag;
    logic [24:0]   r_deg;
    logic          r_sat;

    assign w_last = r_sb[SB-1];
    assign n_ax   = w_last.x[31] ? (~w_last.x + 32'd1) : w_last.x;
    assign n_ay   = w_last.y[31] ? (~w_last.y + 32'd1) : w_last.y;

    always_comb begin
        n_mag = (w_mq[QW-1:32] != '0) ? 32'hFFFF_FFFF : w_mq[31:0];
        n_deg = (w_aq >= QW'(v2p_pkg::DEG360_Q16)) ? '0 : w_aq[24:0];
        priority if (w_last.x == '0 && w_last.y == '0) begin
            n_mag = '0;
            n_deg = '0;
        end else if (w_last.y == '0) begin
            n_mag = n_ax;
            n_deg = w_last.x[31] ? 25'(v2p_pkg::DEG180_Q16) : '0;
        end else if (w_last.x == '0) begin
            n_mag = n_ay;
            n_deg = w_last.y[31] ? 25'(v2p_pkg::DEG270_Q16) : 25'(v2p_pkg::DEG90_Q16);
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.vld;
        end
        r_res_x <= w_last.x;
        r_res_y <= w_last.y;
        r_mag   <= n_mag;
        r_deg   <= n_deg;
        r_sat   <= w_last.sat;
    end

    assign o_done      = r_done;
    assign o_res_x     = r_res_x;
    assign o_res_y     = r_res_y;
    assign o_magnitude = r_mag;
    assign o_angle_deg = r_deg;
    assign o_saturated = r_sat;

endmodule

[src/v2p_checker.sv]
// ============================================================================
// v2p_checker
// port-level checks of the vector unit, bound to the top level
// ============================================================================
module v2p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_done,
    input logic signed [31:0] o_res_x,
    input logic signed [31:0] o_res_y,
    input logic [31:0] o_magnitude,
    input logic [24:0] o_angle_deg
);

    // reset empties the pipe
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // angle stays below a full turn
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle_deg < 25'd23592960))
        else $error("angle out of range");

    // zero vector gives zero length and angle
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res_x == 32'sd0 && o_res_y == 32'sd0)
        |-> (o_magnitude == 32'd0 && o_angle_deg == 25'd0))
        else $error("zero vector polar mismatch");

    // positive x axis is exact
    a_pos_x_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res_y == 32'sd0 && o_res_x > 32'sd0)
        |-> (o_angle_deg == 25'd0 && o_magnitude == $unsigned(o_res_x)))
        else $error("x axis polar mismatch");

endmodule

bind vector2d_alu_with_polar_top v2p_checker u_v2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_done      (o_done),
    .o_res_x     (o_res_x),
    .o_res_y     (o_res_y),
    .o_magnitude (o_magnitude),
    .o_angle_deg (o_angle_deg)
);

[tb/vector2d_alu_with_polar_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector2d_alu_with_polar_checker
// watches the command and result channels, works out the expected result of
// each accepted word and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module vector2d_alu_with_polar_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_scale,
    input  logic               i_done,
    input  logic signed [31:0] i_res_x,
    input  logic signed [31:0] i_res_y,
    input  logic [31:0]        i_magnitude,
    input  logic [24:0]        i_angle_deg,
    input  logic               i_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        mag;
        logic [24:0]        deg;
        logic               sat;
    } t_polar;

    t_polar polar_q[$];
    int     fails;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint arctan_q30(int i);
        longint head[10] = '{843314857, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return head[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_polar vector_result(logic [2:0] fn, longint ax, longint ay,
                                             longint bx, longint by, longint sc);
        t_polar          r;
        longint          rx, ry, cx, cy, z, rad, dx, dy;
        longint unsigned ua, ub, k2, kq, num, d;
        logic            flag;
        flag = 1'b0;
        rx = ax;
        ry = ay;
        case (fn)
            v2p_pkg::FN_ADD: begin
                rx = ax + bx;
                ry = ay + by;
            end
            v2p_pkg::FN_SUB: begin
                rx = ax - bx;
                ry = ay - by;
            end
            v2p_pkg::FN_NEG: begin
                rx = -ax;
                ry = -ay;
            end
            v2p_pkg::FN_SCALE: begin
                rx = shr_floor(ax * sc + (longint'(1) << (v2p_pkg::FRAC_BITS - 1)),
                               v2p_pkg::FRAC_BITS);
                ry = shr_floor(ay * sc + (longint'(1) << (v2p_pkg::FRAC_BITS - 1)),
                               v2p_pkg::FRAC_BITS);
            end
            v2p_pkg::FN_LONGER: begin
                ua = longint'(ax * ax) + longint'(ay * ay);
                ub = longint'(bx * bx) + longint'(by * by);
                if (ub > ua) begin
                    rx = bx;
                    ry = by;
                end
            end
            default: ;  // unused codes load a
        endcase
        rx = clip32(rx, flag);
        ry = clip32(ry, flag);
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.sat = flag;
        if (rx == 0 && ry == 0) begin
            r.mag = '0;
            r.deg = '0;
        end else if (ry == 0) begin
            r.mag = 32'((rx < 0) ? -rx : rx);
            r.deg = (rx > 0) ? 25'd0 : v2p_pkg::DEG180_Q16[24:0];
        end else if (rx == 0) begin
            r.mag = 32'((ry < 0) ? -ry : ry);
            r.deg = (ry > 0) ? v2p_pkg::DEG90_Q16[24:0] : v2p_pkg::DEG270_Q16[24:0];
        end else begin
            cx = ((rx < 0) ? -rx : rx) <<< v2p_pkg::GUARD_BITS;
            cy = ((ry < 0) ? -ry : ry) <<< v2p_pkg::GUARD_BITS;
            z = 0;
            k2 = 64'd1 << 60;
            for (int i = 0; i < v2p_pkg::CORDIC_STAGES && i < 32; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx += dx;
                    cy -= dy;
                    z += arctan_q30(i);
                end else begin
                    cx -= dx;
                    cy += dy;
                    z -= arctan_q30(i);
                end
                k2 = k2 + (k2 >> (2 * i));
            end
            if (z < 0) z = 0;
            if (z > longint'(v2p_pkg::PI_Q30 / 2)) z = longint'(v2p_pkg::PI_Q30 / 2);
            kq = root_floor(k2);
            if (kq == 0) kq = 1;
            num = longint'(cx) << (30 - v2p_pkg::GUARD_BITS);
            num = (num + kq / 2) / kq;
            r.mag = (num > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : num[31:0];
            if (rx > 0 && ry > 0) rad = z;
            else if (rx < 0 && ry > 0) rad = longint'(v2p_pkg::PI_Q30) - z;
            else if (rx < 0) rad = longint'(v2p_pkg::PI_Q30) + z;
            else rad = 2 * longint'(v2p_pkg::PI_Q30) - z;
            d = (longint'(rad) * v2p_pkg::DEG180_Q16 + v2p_pkg::PI_Q30 / 2)
                / v2p_pkg::PI_Q30;
            if (d >= v2p_pkg::DEG360_Q16) d = 0;
            r.deg = d[24:0];
        end
        return r;
    endfunction

    assign o_fail_count = fails;
    assign o_pending    = polar_q.size();

    always @(posedge i_clk) begin
        t_polar want;
        if (!i_rst_n) begin
            polar_q.delete();
            fails = 0;
        end else begin
            if (i_done) begin
                if (polar_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word at %0t", $realtime);
                end else begin
                    want = polar_q.pop_front();
                    if (want.x !== i_res_x || want.y !== i_res_y || want.mag !== i_magnitude
                        || want.deg !== i_angle_deg || want.sat !== i_saturated) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result mismatch: exp x=%h y=%h mag=%h deg=%h sat=%b,",
                                      " got x=%h y=%h mag=%h deg=%h sat=%b"},
                                     want.x, want.y, want.mag, want.deg, want.sat,
                                     i_res_x, i_res_y, i_magnitude, i_angle_deg,
                                     i_saturated);
                    end
                end
            end
            if (i_start && !i_busy)
                polar_q.push_back(vector_result(i_func, i_a_x, i_a_y, i_b_x, i_b_y, i_scale));
        end
    end

endmodule

[tb/vector2d_alu_with_polar_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector2d_alu_with_polar_top_tb
// drives directed and random vector words with random gaps into the block;
// the checker beside it predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module vector2d_alu_with_polar_top_tb;

    localparam int RANDOM_WORDS = 1100;
    localparam int STALL_LIMIT  = 2000;  // idle cycles allowed with nothing accepted or returned

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [2:0]         i_func;
    logic signed [31:0] i_a_x, i_a_y, i_b_x, i_b_y, i_scale;
    logic               o_done;
    logic signed [31:0] o_res_x, o_res_y;
    logic [31:0]        o_magnitude;
    logic [24:0]        o_angle_deg;
    logic               o_saturated;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    vector2d_alu_with_polar_top u_top (.*);

    vector2d_alu_with_polar_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_func,
        .i_a_x, .i_a_y, .i_b_x, .i_b_y, .i_scale,
        .i_done(o_done), .i_res_x(o_res_x), .i_res_y(o_res_y),
        .i_magnitude(o_magnitude), .i_angle_deg(o_angle_deg),
        .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: any accepted word or result restarts the count
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // values near the interesting edges: extremes, zero, within four lsb, one unit; else mid-range or random
    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'(signed'($urandom_range(0, 8)) - 4);
            4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            5, 6: return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // hand one word over, holding start until the block takes it
    task automatic send_word(logic [2:0] fn, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] sc,
                             int gap);
        i_func  <= fn;
        i_a_x   <= ax;
        i_a_y   <= ay;
        i_b_x   <= bx;
        i_b_y   <= by;
        i_scale <= sc;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int gap;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_func  = v2p_pkg::FN_LOAD;
        i_a_x   = '0;
        i_a_y   = '0;
        i_b_x   = '0;
        i_b_y   = '0;
        i_scale = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words: zero vector, axes, every operation, saturation,
        // negating the most negative value, a tie in longer, unused codes
        send_word(v2p_pkg::FN_LOAD, 0, 0, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_LOAD, 32'h0001_0000, 0, 0, 0, 0, 1);
        send_word(v2p_pkg::FN_LOAD, 0, 32'h0001_0000, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_LOAD, 32'hFFFF_0000, 0, 0, 0, 0, 2);
        send_word(v2p_pkg::FN_LOAD, 0, 32'h8000_0000, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_LOAD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_LOAD, 32'h0001_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_ADD, 32'h7FFF_FFFF, 32'h0001_0000, 1, 32'h0002_0000, 0, 0);
        send_word(v2p_pkg::FN_ADD, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h8000_0000, 0, 3);
        send_word(v2p_pkg::FN_SUB, 32'h8000_0000, 32'h0003_0000, 1, 32'h0001_0000, 0, 0);
        send_word(v2p_pkg::FN_SUB, 32'h7FFF_FFFF, 5, 32'hFFFF_FFFF, 7, 0, 0);
        send_word(v2p_pkg::FN_NEG, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0);
        send_word(v2p_pkg::FN_NEG, 32'h0002_8000, 32'hFFFE_0000, 0, 0, 0, 1);
        send_word(v2p_pkg::FN_SCALE, 32'h0003_0000, 32'hFFFD_0000, 0, 0, 32'h0000_8000, 0);
        send_word(v2p_pkg::FN_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000, 0);
        send_word(v2p_pkg::FN_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0);
        send_word(v2p_pkg::FN_SCALE, 32'h0000_0001, 32'h0000_0003, 0, 0, 32'h0000_8000, 0);
        send_word(v2p_pkg::FN_LONGER, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 0, 0, 0);
        send_word(v2p_pkg::FN_LONGER, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0);
        send_word(v2p_pkg::FN_LONGER, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 0, 0);
        send_word(3'd6, 32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 0, 0, 0);
        send_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 0, 0, 0, 0);
        // just below the positive x axis, for an angle that may round up to 360
        send_word(v2p_pkg::FN_LOAD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);

        // hold off until the pipeline is empty
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // runs of back-to-back words alternate with runs of gaps
            gap = ((n / 64) % 2 == 0) ? 0 : $urandom_range(0, 15);
            send_word(3'($urandom_range(0, 7)), pick_component(), pick_component(),
                      pick_component(), pick_component(), pick_component(), gap);
            if (n == RANDOM_WORDS / 2) drain();
        end

        drain();
        repeat (v2p_pkg::LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
